[rtl/core/cpp_pkg.sv]
// shared types and default sizes for the circle pair pushback block
// no dependencies; imported by every module of the block
`default_nettype none

package cpp_pkg;

  // default fixed-point format: Q16.16 on 32-bit coordinates
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 32;

  // per-stage control that travels with each transaction
  typedef struct packed {
    logic vld;
    logic ovl;
    logic nx;
    logic nz;
  } ctl_t;

endpackage

`default_nettype wire

[rtl/core/circle_pair_pushback.sv]
// top level of the circle pair pushback block: front end, square root, scaling, divider
// depends on cpp_pkg, cpp_front, cpp_sqrt and cpp_div
//
// usage:
//   input channel (in_*) carries one circle pair per transaction: centers of A and B as
//   signed fixed point, radii as unsigned fixed point. result channel (out_*) returns one
//   transaction per pair: out_overlapping and A's push along X and Z; B's push is the
//   negation. pairs are independent.
// throughput: one pair per cycle unless a held result stalls; every stage is a register
//   stage under a common advance enable, so a new pair may be offered on every clock.
// pipeline, from input accept to out_valid: three front stages, one root bit per stage,
//   scaling and multiply stages, one quotient bit per divider stage, then the output
//   register.
// stall: while out_valid is high and out_stall is asserted the whole pipeline holds and
//   in_stall is raised in the same cycle; nothing is lost or repeated.
// reset: rst_n low for one clock clears every valid bit; the block then accepts at once.
`default_nettype none

module circle_pair_pushback
  import cpp_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_center_a_x,
  input  wire logic signed [COORD_BITS-1:0] in_center_a_z,
  input  wire logic        [COORD_BITS-2:0] in_radius_a,
  input  wire logic signed [COORD_BITS-1:0] in_center_b_x,
  input  wire logic signed [COORD_BITS-1:0] in_center_b_z,
  input  wire logic        [COORD_BITS-2:0] in_radius_b,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_overlapping,
  output logic signed      [COORD_BITS-1:0] out_push_x,
  output logic signed      [COORD_BITS-1:0] out_push_z
);

  localparam int C        = COORD_BITS;
  localparam int ONE_I    = 1 << FRAC_BITS;
  localparam int EPS_I    = (ONE_I + 5000) / 10000;
  localparam logic [C-1:0] ONE_FX   = C'(ONE_I);
  localparam logic [C-1:0] DIST_EPS = C'(EPS_I);
  localparam int SQ_SIDE  = 3 + 2 * (C + 1) + C;
  localparam logic [C-1:0] POS_LIM = {1'b0, {(C-1){1'b1}}};
  localparam logic [C-1:0] NEG_LIM = {1'b1, {(C-1){1'b0}}};

  // common advance enable: hold everything while a finished result is stalled
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // front end
  ctl_t           fr_ctl;
  logic [C:0]     fr_ax, fr_az;
  logic [C-1:0]   fr_md;
  logic [2*C-1:0] fr_dsq;

  cpp_front #(.COORD_BITS(C)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_valid),
    .ca_x    (in_center_a_x),
    .ca_z    (in_center_a_z),
    .rad_a   (in_radius_a),
    .cb_x    (in_center_b_x),
    .cb_z    (in_center_b_z),
    .rad_b   (in_radius_b),
    .ctl_o   (fr_ctl),
    .ax_o    (fr_ax),
    .az_o    (fr_az),
    .min_d_o (fr_md),
    .dsq_o   (fr_dsq)
  );

  // square root of the squared distance
  logic               sq_vld;
  logic [C-1:0]       sq_root;
  logic [SQ_SIDE-1:0] sq_side;

  cpp_sqrt #(.COORD_BITS(C), .SIDE_W(SQ_SIDE)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (fr_ctl.vld),
    .n_i    (fr_dsq),
    .side_i ({fr_ctl.ovl, fr_ctl.nx, fr_ctl.nz, fr_ax, fr_az, fr_md}),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  logic         sq_ovl, sq_nx, sq_nz;
  logic [C:0]   sq_ax, sq_az;
  logic [C-1:0] sq_md;
  assign {sq_ovl, sq_nx, sq_nz, sq_ax, sq_az, sq_md} = sq_side;

  // near coincident centers fall back to +X at unit distance
  logic              near_w;
  logic [C-1:0]      dist_w;
  logic [C:0]        mx_w, mz_w;
  logic signed [C:0] ov_w;
  logic [C-1:0]      om_w;
  logic              on_w, nx_w, nz_w;

  always_comb begin
    near_w = (sq_root < DIST_EPS) || (sq_root == '0);
    dist_w = near_w ? ONE_FX : sq_root;
    mx_w   = near_w ? {1'b0, ONE_FX} : sq_ax;
    mz_w   = near_w ? '0 : sq_az;
    nx_w   = near_w ? 1'b0 : sq_nx;
    nz_w   = near_w ? 1'b0 : sq_nz;
    ov_w   = $signed({1'b0, sq_md}) - $signed({1'b0, dist_w});
    on_w   = ov_w[C];
    om_w   = on_w ? C'(-ov_w) : ov_w[C-1:0];
  end

  // scaling stage
  logic         sc_vld_r, sc_ovl_r, sc_negx_r, sc_negz_r;
  logic [C:0]   sc_mx_r, sc_mz_r;
  logic [C-1:0] sc_om_r, sc_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else if (en) begin
      sc_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_ovl_r  <= sq_ovl;
      sc_negx_r <= (nx_w != on_w) && (mx_w != '0) && (om_w != '0);
      sc_negz_r <= (nz_w != on_w) && (mz_w != '0) && (om_w != '0);
      sc_mx_r   <= mx_w;
      sc_mz_r   <= mz_w;
      sc_om_r   <= om_w;
      sc_dist_r <= dist_w;
    end
  end

  // multiply stage: magnitude times overlap plus half the divisor for rounding
  logic           mu_vld_r, mu_ovl_r, mu_negx_r, mu_negz_r;
  logic [2*C+1:0] mu_nx_r, mu_nz_r;
  logic [C:0]     mu_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_vld_r <= 1'b0;
    end else if (en) begin
      mu_vld_r <= sc_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_ovl_r  <= sc_ovl_r;
      mu_negx_r <= sc_negx_r;
      mu_negz_r <= sc_negz_r;
      mu_nx_r   <= (2*C+2)'(sc_mx_r * sc_om_r) + (2*C+2)'(sc_dist_r);
      mu_nz_r   <= (2*C+2)'(sc_mz_r * sc_om_r) + (2*C+2)'(sc_dist_r);
      mu_den_r  <= {sc_dist_r, 1'b0};
    end
  end

  // divide by twice the distance
  logic         dv_vld;
  logic [C-1:0] dv_qx, dv_qz;
  logic [2:0]   dv_side;

  cpp_div #(.COORD_BITS(C), .SIDE_W(3)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (mu_vld_r),
    .num_x_i (mu_nx_r),
    .num_z_i (mu_nz_r),
    .den_i   (mu_den_r),
    .side_i  ({mu_ovl_r, mu_negx_r, mu_negz_r}),
    .vld_o   (dv_vld),
    .q_x_o   (dv_qx),
    .q_z_o   (dv_qz),
    .side_o  (dv_side)
  );

  // saturate, apply sign, zero when apart
  logic [C-1:0] limx_w, limz_w, mgx_w, mgz_w;
  always_comb begin
    limx_w = dv_side[1] ? NEG_LIM : POS_LIM;
    limz_w = dv_side[0] ? NEG_LIM : POS_LIM;
    mgx_w  = (dv_qx > limx_w) ? limx_w : dv_qx;
    mgz_w  = (dv_qz > limz_w) ? limz_w : dv_qz;
  end

  logic         out_ovl_r;
  logic [C-1:0] out_px_r, out_pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ovl_r <= dv_side[2];
      out_px_r  <= !dv_side[2] ? '0 : (dv_side[1] ? (~mgx_w + 1'b1) : mgx_w);
      out_pz_r  <= !dv_side[2] ? '0 : (dv_side[0] ? (~mgz_w + 1'b1) : mgz_w);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_overlapping = out_ovl_r;
  assign out_push_x      = out_px_r;
  assign out_push_z      = out_pz_r;

  // apart pairs carry no push
  a_apart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ovl_r |-> (out_px_r == '0) && (out_pz_r == '0))
    else $error("push nonzero for separated circles");

  // input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a held result");

  // half the overlap never reaches the most negative code
  a_push_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_px_r != NEG_LIM) && (out_pz_r != NEG_LIM))
    else $error("push magnitude out of range");

  // a held result stays put while the pipeline is frozen
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sc_dist_r) && $stable(mu_nx_r) && $stable(out_px_r))
    else $error("pipeline moved while frozen");

endmodule

`default_nettype wire

[rtl/core/cpp_front.sv]
// front end: center differences, squares and the overlap compare (three stages)
// depends on cpp_pkg
`default_nettype none

module cpp_front
  import cpp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         vld_i,
  input  wire logic signed [COORD_BITS-1:0] ca_x,
  input  wire logic signed [COORD_BITS-1:0] ca_z,
  input  wire logic        [COORD_BITS-2:0] rad_a,
  input  wire logic signed [COORD_BITS-1:0] cb_x,
  input  wire logic signed [COORD_BITS-1:0] cb_z,
  input  wire logic        [COORD_BITS-2:0] rad_b,
  output ctl_t                              ctl_o,
  output logic             [COORD_BITS:0]   ax_o,
  output logic             [COORD_BITS:0]   az_o,
  output logic             [COORD_BITS-1:0] min_d_o,
  output logic             [2*COORD_BITS-1:0] dsq_o
);

  localparam int C = COORD_BITS;

  // stage 1: differences, magnitudes and radius sum
  logic signed [C:0] dx_w, dz_w;
  ctl_t              s1_ctl_r;
  logic [C:0]        s1_ax_r, s1_az_r;
  logic [C-1:0]      s1_md_r;

  assign dx_w = $signed({ca_x[C-1], ca_x}) - $signed({cb_x[C-1], cb_x});
  assign dz_w = $signed({ca_z[C-1], ca_z}) - $signed({cb_z[C-1], cb_z});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r.vld <= vld_i;
      s1_ctl_r.ovl <= 1'b0;
      s1_ctl_r.nx  <= dx_w[C];
      s1_ctl_r.nz  <= dz_w[C];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax_r <= dx_w[C] ? (~dx_w + 1'b1) : dx_w;
      s1_az_r <= dz_w[C] ? (~dz_w + 1'b1) : dz_w;
      s1_md_r <= {1'b0, rad_a} + {1'b0, rad_b};
    end
  end

  // stage 2: squares
  ctl_t             s2_ctl_r;
  logic [C:0]       s2_ax_r, s2_az_r;
  logic [C-1:0]     s2_md_r;
  logic [2*C+1:0]   s2_sqx_r, s2_sqz_r;
  logic [2*C-1:0]   s2_mdsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (en) begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ax_r   <= s1_ax_r;
      s2_az_r   <= s1_az_r;
      s2_md_r   <= s1_md_r;
      s2_sqx_r  <= s1_ax_r * s1_ax_r;
      s2_sqz_r  <= s1_az_r * s1_az_r;
      s2_mdsq_r <= s1_md_r * s1_md_r;
    end
  end

  // stage 3: squared distance and strict compare
  logic [2*C+1:0] dsq_w;
  assign dsq_w = s2_sqx_r + s2_sqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o.vld <= s2_ctl_r.vld;
      ctl_o.nx  <= s2_ctl_r.nx;
      ctl_o.nz  <= s2_ctl_r.nz;
      ctl_o.ovl <= dsq_w < {2'b00, s2_mdsq_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_o    <= s2_ax_r;
      az_o    <= s2_az_r;
      min_d_o <= s2_md_r;
      dsq_o   <= dsq_w[2*C-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/core/cpp_sqrt.sv]
// pipelined integer square root, one result bit per stage
// depends on cpp_pkg; sideband bits ride along unchanged
`default_nettype none

module cpp_sqrt
  import cpp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SIDE_W     = 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    vld_i,
  input  wire logic [2*COORD_BITS-1:0] n_i,
  input  wire logic [SIDE_W-1:0]       side_i,
  output logic                         vld_o,
  output logic      [COORD_BITS-1:0]   root_o,
  output logic      [SIDE_W-1:0]       side_o
);

  localparam int C = COORD_BITS;

  logic             vld_r  [C];
  logic [C+2:0]     rem_r  [C];
  logic [C-1:0]     root_r [C];
  logic [2*C-1:0]   n_r    [C];
  logic [SIDE_W-1:0] side_r [C];

  for (genvar k = 0; k < C; k++) begin : g_stage
    logic              vld_p;
    logic [C+2:0]      rem_p;
    logic [C-1:0]      root_p;
    logic [2*C-1:0]    n_p;
    logic [SIDE_W-1:0] side_p;
    logic [C+2:0]      rem_sh, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_p  = vld_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign n_p    = n_i;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign n_p    = n_r[k-1];
      assign side_p = side_r[k-1];
    end

    // bring down the next two radicand bits and try the next root bit
    assign rem_sh = {rem_p[C:0], n_p[2*C-1-2*k], n_p[2*C-2-2*k]};
    assign trial  = {1'b0, root_p, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {root_p[C-2:0], ge};
        n_r[k]    <= n_p;
        side_r[k] <= side_p;
      end
    end
  end

  assign vld_o  = vld_r[C-1];
  assign root_o = root_r[C-1];
  assign side_o = side_r[C-1];

endmodule

`default_nettype wire

[rtl/core/cpp_div.sv]
// pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage
// depends on cpp_pkg; quotient is known to fit COORD_BITS bits
`default_nettype none

module cpp_div
  import cpp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SIDE_W     = 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    vld_i,
  input  wire logic [2*COORD_BITS+1:0] num_x_i,
  input  wire logic [2*COORD_BITS+1:0] num_z_i,
  input  wire logic [COORD_BITS:0]     den_i,
  input  wire logic [SIDE_W-1:0]       side_i,
  output logic                         vld_o,
  output logic      [COORD_BITS-1:0]   q_x_o,
  output logic      [COORD_BITS-1:0]   q_z_o,
  output logic      [SIDE_W-1:0]       side_o
);

  localparam int C = COORD_BITS;

  logic              vld_r  [C];
  logic [C:0]        den_r  [C];
  logic [C:0]        rx_r   [C];
  logic [C:0]        rz_r   [C];
  logic [C-1:0]      nx_r   [C];
  logic [C-1:0]      nz_r   [C];
  logic [C-1:0]      qx_r   [C];
  logic [C-1:0]      qz_r   [C];
  logic [SIDE_W-1:0] side_r [C];

  for (genvar k = 0; k < C; k++) begin : g_stage
    logic              vld_p;
    logic [C:0]        den_p, rx_p, rz_p;
    logic [C-1:0]      nx_p, nz_p, qx_p, qz_p;
    logic [SIDE_W-1:0] side_p;
    logic [C+1:0]      shx, shz;
    logic              gex, gez;

    if (k == 0) begin : g_first
      // high part of the dividend is already below the divisor
      assign vld_p  = vld_i;
      assign den_p  = den_i;
      assign rx_p   = num_x_i[2*C:C];
      assign rz_p   = num_z_i[2*C:C];
      assign nx_p   = num_x_i[C-1:0];
      assign nz_p   = num_z_i[C-1:0];
      assign qx_p   = '0;
      assign qz_p   = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign den_p  = den_r[k-1];
      assign rx_p   = rx_r[k-1];
      assign rz_p   = rz_r[k-1];
      assign nx_p   = nx_r[k-1];
      assign nz_p   = nz_r[k-1];
      assign qx_p   = qx_r[k-1];
      assign qz_p   = qz_r[k-1];
      assign side_p = side_r[k-1];
    end

    // shift in the next dividend bit, compare and subtract
    assign shx = {rx_p, nx_p[C-1-k]};
    assign shz = {rz_p, nz_p[C-1-k]};
    assign gex = shx >= {1'b0, den_p};
    assign gez = shz >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= den_p;
        rx_r[k]   <= gex ? (C+1)'(shx - {1'b0, den_p}) : shx[C:0];
        rz_r[k]   <= gez ? (C+1)'(shz - {1'b0, den_p}) : shz[C:0];
        nx_r[k]   <= nx_p;
        nz_r[k]   <= nz_p;
        qx_r[k]   <= {qx_p[C-2:0], gex};
        qz_r[k]   <= {qz_p[C-2:0], gez};
        side_r[k] <= side_p;
      end
    end
  end

  assign vld_o  = vld_r[C-1];
  assign q_x_o  = qx_r[C-1];
  assign q_z_o  = qz_r[C-1];
  assign side_o = side_r[C-1];

endmodule

`default_nettype wire

[test/tb_circle_pair_pushback.sv]
// testbench for circle_pair_pushback: random and directed circle pairs, push checked
// against an in-bench predictor of overlap, root, and rounded division
// depends on cpp_pkg and the circle_pair_pushback rtl
`timescale 1ns / 100ps
`default_nettype none

module tb_circle_pair_pushback;
  import cpp_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int FW = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FW;
  localparam longint NEAR_EPS = (ONE + 5000) / 10000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1950;
  localparam logic signed [CW-1:0] ONE_C = CW'(ONE);
  localparam logic [CW-2:0] ONE_R = (CW-1)'(ONE);

  typedef struct {
    logic ovl;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] pz;
  } push_t;

  // expected pushes in arrival order
  class push_scoreboard;
    push_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // rounded magnitude division, sign applied, saturated
    function logic signed [CW-1:0] scaled(logic [127:0] mag, logic neg, logic [127:0] om,
                                          logic [127:0] dlen);
      logic [127:0] q;
      logic [127:0] lim;
      q = (mag * om + dlen) / (dlen << 1);
      lim = neg ? (128'd1 << (CW - 1)) : ((128'd1 << (CW - 1)) - 1);
      if (q > lim) q = lim;
      if (neg) q = -q;
      return q[CW-1:0];
    endfunction

    function logic [127:0] isqrt(logic [127:0] n);
      logic [127:0] r;
      logic [127:0] t;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        t = r | (128'd1 << b);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    function void note_pair(logic signed [CW-1:0] ax, logic signed [CW-1:0] az,
                            logic [CW-2:0] ra, logic signed [CW-1:0] bx,
                            logic signed [CW-1:0] bz, logic [CW-2:0] rb);
      longint dx;
      longint dz;
      logic [127:0] mx;
      logic [127:0] mz;
      logic [127:0] rsum;
      logic [127:0] dlen;
      logic [127:0] om;
      logic nx;
      logic nz;
      logic on;
      longint ov;
      push_t e;
      dx = longint'(ax) - longint'(bx);
      dz = longint'(az) - longint'(bz);
      nx = dx < 0;
      nz = dz < 0;
      mx = nx ? -dx : dx;
      mz = nz ? -dz : dz;
      rsum = ra + rb;
      e = '{1'b0, '0, '0};
      if (mx * mx + mz * mz < rsum * rsum) begin
        dlen = isqrt(mx * mx + mz * mz);
        // near coincident centers: push along +x with unit distance
        if (dlen < NEAR_EPS || dlen == 0) begin
          mx = ONE;
          mz = 0;
          nx = 0;
          nz = 0;
          dlen = ONE;
        end
        ov = longint'(rsum) - longint'(dlen);
        on = ov < 0;
        om = on ? -ov : ov;
        e.ovl = 1'b1;
        e.px = scaled(mx, (nx != on) && mx != 0 && om != 0, om, dlen);
        e.pz = scaled(mz, (nz != on) && mz != 0 && om != 0, om, dlen);
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic ovl, logic signed [CW-1:0] px, logic signed [CW-1:0] pz);
      push_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result ovl=%0d x=%0d z=%0d", $time, ovl, px, pz);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (ovl !== e.ovl) begin
        $display("%0t: overlapping expected %0d actual %0d", $time, e.ovl, ovl);
        errors++;
      end
      if (px !== e.px) begin
        $display("%0t: push_x expected %0d actual %0d", $time, e.px, px);
        errors++;
      end
      if (pz !== e.pz) begin
        $display("%0t: push_z expected %0d actual %0d", $time, e.pz, pz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [CW-1:0] in_center_a_x = '0;
  logic signed [CW-1:0] in_center_a_z = '0;
  logic [CW-2:0] in_radius_a = '0;
  logic signed [CW-1:0] in_center_b_x = '0;
  logic signed [CW-1:0] in_center_b_z = '0;
  logic [CW-2:0] in_radius_b = '0;
  logic out_valid;
  logic out_stall = 0;
  logic out_overlapping;
  logic signed [CW-1:0] out_push_x;
  logic signed [CW-1:0] out_push_z;

  push_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;

  always #2 clk = ~clk;

  circle_pair_pushback DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_center_a_x(in_center_a_x), .in_center_a_z(in_center_a_z),
    .in_radius_a(in_radius_a), .in_center_b_x(in_center_b_x),
    .in_center_b_z(in_center_b_z), .in_radius_b(in_radius_b),
    .out_valid(out_valid), .out_stall(out_stall), .out_overlapping(out_overlapping),
    .out_push_x(out_push_x), .out_push_z(out_push_z)
  );

  // accepted transactions on both sides, plus the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_pair(in_center_a_x, in_center_a_z, in_radius_a, in_center_b_x,
                     in_center_b_z, in_radius_b);
      if (out_valid && !out_stall)
        sb.check_result(out_overlapping, out_push_x, out_push_z);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver stall pattern: none, or random at one of two rates
  always @(negedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 7) < 3);
      default: out_stall <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // offer one pair and hold it until accepted
  task automatic send_pair(logic signed [CW-1:0] ax, logic signed [CW-1:0] az,
                           logic [CW-2:0] ra, logic signed [CW-1:0] bx,
                           logic signed [CW-1:0] bz, logic [CW-2:0] rb);
    in_center_a_x <= ax;
    in_center_a_z <= az;
    in_radius_a <= ra;
    in_center_b_x <= bx;
    in_center_b_z <= bz;
    in_radius_b <= rb;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic rest(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [CW-1:0] rnd_coord(int shape);
    case (shape)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 'h7_FFFF)) - 'sh4_0000;
      default: return $signed($urandom_range(0, 'h3F)) - 'sh20;
    endcase
  endfunction

  function automatic logic [CW-2:0] rnd_radius(int shape);
    case (shape)
      0: return (CW-1)'($urandom());
      1: return (CW-1)'($urandom_range(0, 'h8_0000));
      default: return (CW-1)'($urandom_range(0, 'h2_0000));
    endcase
  endfunction

  task automatic send_random();
    int s;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] az;
    s = $urandom_range(0, 9);
    ax = rnd_coord(s < 2 ? 0 : 1);
    az = rnd_coord(s < 2 ? 0 : 1);
    // near pairs mostly, so overlap and the near coincident path are exercised
    if (s >= 7)
      send_pair(ax, az, rnd_radius(2), ax + rnd_coord(2), az + rnd_coord(2), rnd_radius(2));
    else if (s >= 2)
      send_pair(ax, az, rnd_radius(1), ax + rnd_coord(1), az + rnd_coord(1), rnd_radius(1));
    else
      send_pair(ax, az, rnd_radius(0), rnd_coord(0), rnd_coord(0), rnd_radius(0));
  endtask

  localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-2:0] MAXR = '1;

  initial begin
    int burst;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(0, 0, ONE_R, 0, 0, ONE_R);
    send_pair(0, 0, 'h4000, 3, 2, 'h2000);
    send_pair(5, 0, 'h100, 0, 0, 'h100);
    send_pair(0, 0, ONE_R, ONE_C, 0, ONE_R);
    send_pair(0, 0, ONE_R, 0, 2 * ONE_C, ONE_R);
    send_pair(0, 0, ONE_R, -ONE_C, -ONE_C, ONE_R);
    send_pair(MAXC, MAXC, MAXR, MINC, MINC, MAXR);
    send_pair(MINC, MAXC, MAXR, MAXC, MINC, MAXR);
    send_pair(MAXC, 0, MAXR, MAXC - 1, 0, MAXR);
    send_pair(MINC, MINC, 0, MAXC, MAXC, 0);
    send_pair(MAXC, MAXC, 0, MAXC, MAXC, 1);
    send_pair(0, 0, MAXR, 7, 0, 0);
    send_pair(0, 0, MAXR, 6, 0, 0);
    send_pair(0, 0, 1, 0, 0, 1);
    send_pair('h5555_5555, 'hAAAA_AAAA, 'h5555_5555, 'hAAAA_AAAA, 'h5555_5555, 'h2AAA_AAAA);
    send_pair('hAAAA_AAAA, 'h5555_5555, 'h2AAA_AAAA, 'h5555_5555, 'hAAAA_AAAA, 'h5555_5555);

    // hold off until the pipeline has drained
    rest(1);
    while (sb.pending.size() != 0) @(negedge clk);

    // random bursts with gaps, receiver pattern changing per phase
    for (int n = 0; n < N_RANDOM; ) begin
      stall_mode = (n / 300) % 3;
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) send_random();
      if ($urandom_range(0, 2) != 0) rest($urandom_range(1, 12));
    end
    rest(1);
    stall_mode = 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (2 * CW + 20) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
